[rtl/htmin_pkg.sv]
`default_nettype none

package htmin_pkg;

  // Window geometry: 8 look-ahead bytes plus the byte being decided
  localparam int WinDepth = 8;
  localparam int BufDepth = WinDepth + 1;
  localparam int FillW    = $clog2(BufDepth + 1);
  localparam int CfgIdxW  = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgRemoveComments = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOptimizeWs     = 2'd1;

  // Characters
  localparam logic [7:0] ChLt     = 8'h3C; // '<'
  localparam logic [7:0] ChGt     = 8'h3E; // '>'
  localparam logic [7:0] ChBang   = 8'h21; // '!'
  localparam logic [7:0] ChDash   = 8'h2D; // '-'
  localparam logic [7:0] ChQuot   = 8'h22; // '"'
  localparam logic [7:0] ChApos   = 8'h27; // '\''
  localparam logic [7:0] ChBslash = 8'h5C; // '\\'
  localparam logic [7:0] ChSpace  = 8'h20; // ' '

  // Markers, first character in the top byte
  localparam logic [31:0] MkCmtOpen  = "<!--";
  localparam logic [23:0] MkCmtClose = "-->";
  localparam logic [55:0] MkScript   = "<script";
  localparam logic [47:0] MkStyle    = "<style";
  localparam logic [71:0] MkEScript  = "</script>";
  localparam logic [63:0] MkEStyle   = "</style>";

  // One queued input transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } htmin_item_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
            (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

`default_nettype wire

[rtl/html_text_minifier_unit.sv]
`default_nettype none

// Channel   Handshake                   Payload
// input     in_valid / in_ready         in_byte, in_last_byte
// result    out_item_valid / out_ready  out_byte, out_valid, out_end_of_text
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A two-entry queue takes input bytes; the back end pops one when idle.
// A byte that only fills the look-ahead window is just stored; a decided byte
// goes through decide, then emits its result bytes one at a time (up to 4 for a comment marker).
// A flush decides and emits every window byte in turn, then sends the end item.
// Reset is synchronous, active low; no clearing pass. cfg_ready is always high.
// A stalled result register holds the back end; the queue keeps taking input until both entries are full.

module html_text_minifier_unit
  import htmin_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last_byte,
  output logic                    out_item_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_valid,
  output logic                    out_end_of_text,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic               cfg_data
);

  htmin_item_t q_item;
  logic        q_valid;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  htmin_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  htmin_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_item_valid  (out_item_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_end_of_text (out_end_of_text)
  );

endmodule

`default_nettype wire

[rtl/htmin_front.sv]
`default_nettype none

module htmin_front
  import htmin_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last_byte,
  output logic             q_valid,
  output htmin_item_t      q_item,
  input  wire logic        q_pop
);

  // Two-entry queue between input port and the window engine
  htmin_item_t q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{data: in_byte, last: in_last_byte};
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop && q_valid) rd_ptr_r <= ~rd_ptr_r;
      case ({push, q_pop && q_valid})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/htmin_back.sv]
`default_nettype none

module htmin_back
  import htmin_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // config writes
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic               cfg_data,
  // queue side
  input  wire logic               q_valid,
  input  wire htmin_item_t        q_item,
  output logic                    q_pop,
  // result side
  output logic                    out_item_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_valid,
  output logic                    out_end_of_text
);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_EMIT, S_END} state_t;

  state_t           state_r;
  logic [7:0]       buf_r [BufDepth];
  logic [FillW-1:0] fill_r;
  logic             flush_r;

  // text state
  logic [7:0] prev_r;
  logic       seen_r;
  logic [1:0] skip_r;
  logic       in_cmt_r, in_tag_r, in_quote_r, in_scr_r, in_sty_r;
  logic [7:0] qchar_r;
  logic       lws_r;
  logic [7:0] lsent_r;
  logic       any_sent_r;

  // registers
  logic rm_cmt_r, opt_ws_r;

  // emit sequencer and end-of-text hold
  logic [31:0] emit_sr_r;
  logic [2:0]  emit_cnt_r;
  logic        hold_vld_r;
  logic [7:0]  hold_byte_r;

  logic       out_item_valid_r, out_valid_r, out_eot_r;
  logic [7:0] out_byte_r;

  // decide results
  logic [1:0]  skip_nxt;
  logic        in_cmt_nxt, in_tag_nxt, in_quote_nxt, in_scr_nxt, in_sty_nxt;
  logic [7:0]  qchar_nxt;
  logic        lws_nxt;
  logic [7:0]  lsent_nxt;
  logic        any_sent_nxt;
  logic [31:0] emit_nxt;
  logic [2:0]  emit_len_nxt;

  logic [8*BufDepth-1:0] win_w;
  logic [7:0]            c;
  logic                  keep;
  logic m_open, m_close, m_script, m_style, m_escript, m_estyle;
  logic scr_v, sty_v;
  logic out_free;
  logic [FillW-1:0] fill_dec;

  assign out_item_valid  = out_item_valid_r;
  assign out_byte        = out_byte_r;
  assign out_valid       = out_valid_r;
  assign out_end_of_text = out_eot_r;

  assign out_free = !out_item_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign fill_dec = fill_r - FillW'(1);

  // Window as one word, oldest byte on top
  always_comb begin
    for (int i = 0; i < BufDepth; i++) begin
      win_w[8*(BufDepth-1-i) +: 8] = buf_r[i];
    end
  end

  assign c    = buf_r[0];
  assign keep = !rm_cmt_r;

  // Marker matches, only over bytes that are present
  assign m_open    = (fill_r >= FillW'(4)) && (win_w[8*BufDepth-1 -: 32] == MkCmtOpen);
  assign m_close   = (fill_r >= FillW'(3)) && (win_w[8*BufDepth-1 -: 24] == MkCmtClose);
  assign m_script  = (fill_r >= FillW'(7)) && (win_w[8*BufDepth-1 -: 56] == MkScript);
  assign m_style   = (fill_r >= FillW'(6)) && (win_w[8*BufDepth-1 -: 48] == MkStyle);
  assign m_escript = (fill_r >= FillW'(9)) && (win_w[8*BufDepth-1 -: 72] == MkEScript);
  assign m_estyle  = (fill_r >= FillW'(8)) && (win_w[8*BufDepth-1 -: 64] == MkEStyle);

  // Decision for the oldest window byte
  always_comb begin
    skip_nxt     = skip_r;
    in_cmt_nxt   = in_cmt_r;
    in_tag_nxt   = in_tag_r;
    in_quote_nxt = in_quote_r;
    in_scr_nxt   = in_scr_r;
    in_sty_nxt   = in_sty_r;
    qchar_nxt    = qchar_r;
    lws_nxt      = lws_r;
    emit_nxt     = {c, 24'd0};
    emit_len_nxt = 3'd0;
    scr_v        = in_scr_r;
    sty_v        = in_sty_r;

    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (!in_quote_r && !in_cmt_r && m_open) begin
      emit_nxt     = MkCmtOpen;
      emit_len_nxt = keep ? 3'd4 : 3'd0;
      in_cmt_nxt   = 1'b1;
      skip_nxt     = 2'd3;
    end else if (in_cmt_r && m_close) begin
      emit_nxt     = {MkCmtClose, 8'd0};
      emit_len_nxt = keep ? 3'd3 : 3'd0;
      in_cmt_nxt   = 1'b0;
      skip_nxt     = 2'd2;
    end else if (in_cmt_r) begin
      emit_len_nxt = keep ? 3'd1 : 3'd0;
    end else begin
      // script / style body tracking
      if (!in_quote_r) begin
        if (m_script)       scr_v = 1'b1;
        else if (m_style)   sty_v = 1'b1;
        else if (m_escript) scr_v = 1'b0;
        else if (m_estyle)  sty_v = 1'b0;
      end
      in_scr_nxt = scr_v;
      in_sty_nxt = sty_v;

      if (scr_v || sty_v) begin
        emit_len_nxt = 3'd1;
      end else if (!in_quote_r && c == ChLt) begin
        in_tag_nxt   = 1'b1;
        emit_len_nxt = 3'd1;
        lws_nxt      = 1'b0;
      end else if (!in_quote_r && c == ChGt) begin
        in_tag_nxt   = 1'b0;
        emit_len_nxt = 3'd1;
        lws_nxt      = 1'b0;
      end else if (in_tag_r && !in_quote_r && (c == ChQuot || c == ChApos)) begin
        in_quote_nxt = 1'b1;
        qchar_nxt    = c;
        emit_len_nxt = 3'd1;
      end else if (in_quote_r && c == qchar_r && !(seen_r && prev_r == ChBslash)) begin
        in_quote_nxt = 1'b0;
        emit_len_nxt = 3'd1;
      end else if (in_quote_r) begin
        emit_len_nxt = 3'd1;
      end else if (!in_tag_r && is_ws(c)) begin
        if (!lws_r && any_sent_r && lsent_r != ChGt && opt_ws_r) begin
          emit_nxt     = {ChSpace, 24'd0};
          emit_len_nxt = 3'd1;
          lws_nxt      = 1'b1;
        end
      end else begin
        emit_len_nxt = 3'd1;
        lws_nxt      = 1'b0;
      end
    end

    // last byte sent follows the emitted string
    any_sent_nxt = any_sent_r || (emit_len_nxt != 3'd0);
    case (emit_len_nxt)
      3'd1:    lsent_nxt = emit_nxt[31:24];
      3'd3:    lsent_nxt = emit_nxt[15:8];
      3'd4:    lsent_nxt = emit_nxt[7:0];
      default: lsent_nxt = lsent_r;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_cmt_r <= 1'b1;
      opt_ws_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgRemoveComments: rm_cmt_r <= cfg_data;
        CfgOptimizeWs:     opt_ws_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Window data
  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[fill_r] <= q_item.data;
    end else if (state_r == S_DECIDE) begin
      for (int i = 0; i < BufDepth - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  // Sequencer, text state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      fill_r           <= '0;
      flush_r          <= 1'b0;
      prev_r           <= 8'd0;
      seen_r           <= 1'b0;
      skip_r           <= 2'd0;
      in_cmt_r         <= 1'b0;
      in_tag_r         <= 1'b0;
      in_quote_r       <= 1'b0;
      in_scr_r         <= 1'b0;
      in_sty_r         <= 1'b0;
      qchar_r          <= 8'd0;
      lws_r            <= 1'b0;
      lsent_r          <= 8'd0;
      any_sent_r       <= 1'b0;
      emit_cnt_r       <= 3'd0;
      hold_vld_r       <= 1'b0;
      out_item_valid_r <= 1'b0;
    end else begin
      if (out_item_valid_r && out_ready) out_item_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            fill_r <= fill_r + FillW'(1);
            if (q_item.last) begin
              flush_r <= 1'b1;
              state_r <= S_DECIDE;
            end else if (fill_r == FillW'(WinDepth)) begin
              state_r <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          skip_r     <= skip_nxt;
          in_cmt_r   <= in_cmt_nxt;
          in_tag_r   <= in_tag_nxt;
          in_quote_r <= in_quote_nxt;
          in_scr_r   <= in_scr_nxt;
          in_sty_r   <= in_sty_nxt;
          qchar_r    <= qchar_nxt;
          lws_r      <= lws_nxt;
          lsent_r    <= lsent_nxt;
          any_sent_r <= any_sent_nxt;
          prev_r     <= c;
          seen_r     <= 1'b1;
          fill_r     <= fill_dec;
          emit_sr_r  <= emit_nxt;
          emit_cnt_r <= emit_len_nxt;
          if (emit_len_nxt != 3'd0) begin
            state_r <= S_EMIT;
          end else if (!flush_r) begin
            state_r <= S_IDLE;
          end else if (fill_dec == '0) begin
            state_r <= S_END;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            // during a flush one byte is held back to tag the end
            if (!flush_r || hold_vld_r) begin
              out_item_valid_r <= 1'b1;
              out_byte_r       <= flush_r ? hold_byte_r : emit_sr_r[31:24];
              out_valid_r      <= 1'b1;
              out_eot_r        <= 1'b0;
            end
            if (flush_r) begin
              hold_vld_r  <= 1'b1;
              hold_byte_r <= emit_sr_r[31:24];
            end
            emit_sr_r  <= {emit_sr_r[23:0], 8'd0};
            emit_cnt_r <= emit_cnt_r - 3'd1;
            if (emit_cnt_r == 3'd1) begin
              if (!flush_r) begin
                state_r <= S_IDLE;
              end else if (fill_r == '0) begin
                state_r <= S_END;
              end else begin
                state_r <= S_DECIDE;
              end
            end
          end
        end

        S_END: begin
          if (out_free) begin
            out_item_valid_r <= 1'b1;
            out_byte_r       <= hold_vld_r ? hold_byte_r : 8'd0;
            out_valid_r      <= hold_vld_r;
            out_eot_r        <= 1'b1;
            hold_vld_r       <= 1'b0;
            flush_r          <= 1'b0;
            fill_r           <= '0;
            prev_r           <= 8'd0;
            seen_r           <= 1'b0;
            skip_r           <= 2'd0;
            in_cmt_r         <= 1'b0;
            in_tag_r         <= 1'b0;
            in_quote_r       <= 1'b0;
            in_scr_r         <= 1'b0;
            in_sty_r         <= 1'b0;
            qchar_r          <= 8'd0;
            lws_r            <= 1'b0;
            lsent_r          <= 8'd0;
            any_sent_r       <= 1'b0;
            state_r          <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/html_text_minifier_unit_test.sv]
module html_text_minifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import htmin_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 80;

  // Index past the register list; a write to it must change nothing
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  localparam int LenCmtOpen  = $bits(MkCmtOpen) / 8;
  localparam int LenCmtClose = $bits(MkCmtClose) / 8;
  localparam int LenScript   = $bits(MkScript) / 8;
  localparam int LenStyle    = $bits(MkStyle) / 8;
  localparam int LenEScript  = $bits(MkEScript) / 8;
  localparam int LenEStyle   = $bits(MkEStyle) / 8;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eot;
  } minified_char_t;

  // DUT ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = 8'h00;
  logic               in_last_byte = 1'b0;
  logic               out_item_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_valid;
  logic               out_end_of_text;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic               cfg_data = 1'b0;

  // Stimulus and scoreboard storage
  htmin_item_t    pending_chars[$];
  minified_char_t expected_chars[$];
  logic [7:0]     text_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;
  int cycle_count = 0;

  // Minifier shadow state
  bit         cfg_drop_comments = 1'b1;
  bit         cfg_fold_ws = 1'b1;
  logic [7:0] win_q [WinDepth];
  logic [7:0] text_buf [BufDepth];
  int         win_fill = 0;
  logic [7:0] prev_ch = 8'h00;
  bit         seen_ch = 1'b0;
  int         skip_left = 0;
  bit         cmt_on = 1'b0;
  bit         tag_on = 1'b0;
  bit         quote_on = 1'b0;
  logic [7:0] quote_ch = 8'h00;
  bit         script_on = 1'b0;
  bit         style_on = 1'b0;
  bit         ws_folded = 1'b0;
  logic [7:0] last_out_ch = 8'h00;
  bit         any_out = 1'b0;

  html_text_minifier_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_byte    (in_last_byte),
    .out_item_valid  (out_item_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_end_of_text (out_end_of_text),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Minifier prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  // Marker must be complete within the known bytes; first char in top byte
  function automatic bit marker_at(input int base, input int avail,
                                   input logic [71:0] mk, input int len);
    int k;
    marker_at = 1'b1;
    for (k = 0; k < len; k++)
      if (k >= avail || text_buf[base + k] != mk[(len - 1 - k) * 8 +: 8])
        marker_at = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] c);
    minified_char_t mc;
    mc.data  = c;
    mc.valid = 1'b1;
    mc.eot   = 1'b0;
    expected_chars.insert(expected_chars.size(), mc);
    last_out_ch = c;
    any_out = 1'b1;
  endfunction

  function automatic void emit_marker(input logic [71:0] mk, input int len);
    int k;
    for (k = 0; k < len; k++)
      emit(mk[(len - 1 - k) * 8 +: 8]);
  endfunction

  function automatic void clear_text_state();
    int k;
    for (k = 0; k < WinDepth; k++)
      win_q[k] = 8'h00;
    win_fill = 0;
    prev_ch = 8'h00;
    seen_ch = 1'b0;
    skip_left = 0;
    cmt_on = 1'b0;
    tag_on = 1'b0;
    quote_on = 1'b0;
    quote_ch = 8'h00;
    script_on = 1'b0;
    style_on = 1'b0;
    ws_folded = 1'b0;
    last_out_ch = 8'h00;
    any_out = 1'b0;
  endfunction

  // Settle the char at text_buf[base]; avail counts it plus the known later chars
  function automatic void decide_char(input int base, input int avail);
    logic [7:0] c;
    bit         copy_cmt;
    c = text_buf[base];
    copy_cmt = !cfg_drop_comments;
    if (skip_left > 0) begin
      skip_left--;
    end else if (!quote_on && !cmt_on &&
                 marker_at(base, avail, 72'(MkCmtOpen), LenCmtOpen)) begin
      if (copy_cmt) emit_marker(72'(MkCmtOpen), LenCmtOpen);
      cmt_on = 1'b1;
      skip_left = LenCmtOpen - 1;
    end else if (cmt_on && marker_at(base, avail, 72'(MkCmtClose), LenCmtClose)) begin
      if (copy_cmt) emit_marker(72'(MkCmtClose), LenCmtClose);
      cmt_on = 1'b0;
      skip_left = LenCmtClose - 1;
    end else if (cmt_on) begin
      if (copy_cmt) emit(c);
    end else begin
      if (!quote_on) begin
        if (marker_at(base, avail, 72'(MkScript), LenScript))
          script_on = 1'b1;
        else if (marker_at(base, avail, 72'(MkStyle), LenStyle))
          style_on = 1'b1;
        else if (marker_at(base, avail, MkEScript, LenEScript))
          script_on = 1'b0;
        else if (marker_at(base, avail, 72'(MkEStyle), LenEStyle))
          style_on = 1'b0;
      end
      if (script_on || style_on) begin
        emit(c);
      end else if (!quote_on && c == ChLt) begin
        tag_on = 1'b1;
        emit(c);
        ws_folded = 1'b0;
      end else if (!quote_on && c == ChGt) begin
        tag_on = 1'b0;
        emit(c);
        ws_folded = 1'b0;
      end else if (tag_on && !quote_on && (c == ChQuot || c == ChApos)) begin
        quote_on = 1'b1;
        quote_ch = c;
        emit(c);
      end else if (quote_on && c == quote_ch && !(seen_ch && prev_ch == ChBslash)) begin
        quote_on = 1'b0;
        emit(c);
      end else if (quote_on) begin
        emit(c);
      end else if (!tag_on && is_blank(c)) begin
        if (!ws_folded && any_out && last_out_ch != ChGt && cfg_fold_ws) begin
          emit(ChSpace);
          ws_folded = 1'b1;
        end
      end else begin
        emit(c);
        ws_folded = 1'b0;
      end
    end
    prev_ch = c;
    seen_ch = 1'b1;
  endfunction

  // One accepted input transaction: queue the result transactions it causes
  function automatic void minify_char(input logic [7:0] ch, input logic last);
    int             n;
    int             k;
    int             first;
    minified_char_t mc;
    first = expected_chars.size();
    n = win_fill;
    for (k = 0; k < n; k++)
      text_buf[k] = win_q[k];
    text_buf[n] = ch;
    n++;
    if (!last) begin
      if (n == BufDepth) begin
        decide_char(0, n);
        for (k = 0; k < WinDepth; k++)
          win_q[k] = text_buf[k + 1];
        win_fill = WinDepth;
      end else begin
        for (k = 0; k < n; k++)
          win_q[k] = text_buf[k];
        win_fill = n;
      end
    end else begin
      // flush the whole window, then mark the end of the text
      for (k = 0; k < n; k++)
        decide_char(k, n - k);
      if (expected_chars.size() > first) begin
        expected_chars[expected_chars.size() - 1].eot = 1'b1;
      end else begin
        mc.data  = 8'h00;
        mc.valid = 1'b0;
        mc.eot   = 1'b1;
        expected_chars.insert(expected_chars.size(), mc);
      end
      clear_text_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor, configuration, hold-off and watchdog
  // ---------------------------------------------------------------------------

  // Input driver: valid stays up until the transaction is taken
  always @(posedge clk) begin : text_driver
    htmin_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        minify_char(in_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          in_valid     <= 1'b1;
          in_byte      <= nxt.data;
          in_last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expected transaction
  always @(posedge clk) begin : result_monitor
    minified_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_item_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result transaction: out_byte %02h out_valid %0b out_end_of_text %0b",
                 out_byte, out_valid, out_end_of_text);
          err_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            err_count++;
          end
          if (out_valid !== want.valid) begin
            $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
            err_count++;
          end
          if (out_end_of_text !== want.eot) begin
            $error("out_end_of_text: expected %0b, got %0b", want.eot, out_end_of_text);
            err_count++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Register write channel: drop valid once taken, mirror into the shadow copy
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgRemoveComments: cfg_drop_comments = cfg_data;
        CfgOptimizeWs:     cfg_fold_ws = cfg_data;
        default: ;
      endcase
      cfg_valid <= 1'b0;
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("html_text_minifier_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_ch(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void add_str(input string s);
    int k;
    for (k = 0; k < s.len(); k++)
      text_q.insert(text_q.size(), s[k]);
  endfunction

  function automatic void add_word(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
      text_q.insert(text_q.size(), c);
    end
  endfunction

  function automatic void add_blanks(input int n);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: add_ch(8'h20);
        1: add_ch(8'h09);
        2: add_ch(8'h0A);
        3: add_ch(8'h0B);
        4: add_ch(8'h0C);
        default: add_ch(8'h0D);
      endcase
    end
  endfunction

  // Chars that stress markers and quoting inside bodies and strings
  function automatic void add_body_char();
    case ($urandom_range(0, 11))
      0, 1, 2: add_word(1);
      3:       add_blanks(1);
      4:       add_ch(ChLt);
      5:       add_ch(ChGt);
      6:       add_ch(ChQuot);
      7:       add_ch(ChApos);
      8:       add_ch(ChBslash);
      9:       add_ch(ChDash);
      10:      add_ch("/");
      default: add_ch(ChBang);
    endcase
  endfunction

  // Hand the built text to the driver, last flag on its final char
  task automatic queue_text();
    int          k;
    htmin_item_t it;
    @(negedge clk);
    for (k = 0; k < text_q.size(); k++) begin
      it.data = text_q[k];
      it.last = (k == text_q.size() - 1);
      pending_chars.insert(pending_chars.size(), it);
    end
    text_q.delete();
  endtask

  // Mostly well-formed HTML fragments with random content, some noise
  task automatic gen_random_text(output int len);
    int         target;
    int         n;
    int         k;
    logic [7:0] qc;
    text_q.delete();
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    while (text_q.size() < target) begin
      case ($urandom_range(0, 15))
        0, 1: add_word($urandom_range(1, 6));
        2, 3: add_blanks($urandom_range(1, 3));
        4, 5: begin
          // opening tag with quoted attributes, escaped quotes inside
          add_ch(ChLt);
          add_word($urandom_range(1, 4));
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) begin
            add_blanks(1);
            add_word($urandom_range(1, 3));
            add_ch("=");
            qc = $urandom_range(0, 1) ? ChQuot : ChApos;
            add_ch(qc);
            repeat ($urandom_range(0, 5)) begin
              if ($urandom_range(0, 4) == 0) begin
                add_ch(ChBslash);
                add_ch(qc);
              end else begin
                add_body_char();
              end
            end
            add_ch(qc);
          end
          if ($urandom_range(0, 1) != 0) add_blanks(1);
          add_ch(ChGt);
        end
        6: begin
          add_str("</");
          add_word($urandom_range(1, 4));
          add_ch(ChGt);
        end
        7, 8: begin
          add_str("<!--");
          repeat ($urandom_range(0, 6)) add_body_char();
          if ($urandom_range(0, 4) != 0) add_str("-->");
        end
        9: begin
          add_str("<script>");
          repeat ($urandom_range(0, 8)) add_body_char();
          if ($urandom_range(0, 4) != 0) add_str("</script>");
        end
        10: begin
          add_str("<style>");
          repeat ($urandom_range(0, 8)) add_body_char();
          if ($urandom_range(0, 4) != 0) add_str("</style>");
        end
        11: begin
          // partial or stray markers
          case ($urandom_range(0, 5))
            0: add_str("<!-");
            1: add_str("<scr");
            2: add_str("</styl");
            3: add_str("-->");
            4: add_str("<!-- -");
            default: add_str("</script");
          endcase
        end
        12: add_ch(8'($urandom_range(0, 255)));
        13: add_body_char();
        default: add_word($urandom_range(1, 3));
      endcase
    end
    len = text_q.size();
    queue_text();
  endtask

  task automatic run_random(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      gen_random_text(len);
      sent += len;
    end
  endtask

  // Sender pauses until every result is in, then lets trailing work finish
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (cfg_valid);
  endtask

  task automatic set_mode(input logic drop_cmt, input logic fold_ws);
    write_reg(CfgRemoveComments, drop_cmt);
    write_reg(CfgOptimizeWs, fold_ws);
  endtask

  task automatic set_pacing(input int idle_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts under reset settings
    add_ch(8'h00);
    queue_text();
    add_ch(8'hFF);
    queue_text();
    add_str("<!--c-->");
    queue_text();
    add_str("<i a=\"\\\"\">");   // escaped quote does not close the string
    queue_text();
    add_ch(8'h20);
    add_ch("x");
    add_ch(8'h09);
    add_ch(8'h0D);
    add_ch("y");
    queue_text();
    add_ch(8'h0A);                // text with no output: empty end item
    add_ch(8'h0B);
    queue_text();
    wait_drained();

    // Copy comments, drop whitespace, no idling; unmapped index ignored
    set_mode(1'b0, 1'b0);
    write_reg(CfgUnmapped, 1'b1);
    set_pacing(0, 0);
    run_random(90);
    wait_drained();

    // Drop comments and whitespace, sender mostly idle
    set_mode(1'b1, 1'b0);
    set_pacing(84, 0);
    run_random(90);
    wait_drained();

    // Copy comments, fold whitespace, receiver mostly stalled, pause midway
    set_mode(1'b0, 1'b1);
    set_pacing(0, 84);
    run_random(40);
    wait_drained();
    run_random(40);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    set_pacing(0, 0);
    hold_left = 500;
    run_random(45);
    wait_drained();

    // Defaults back, light idling on both sides
    set_mode(1'b1, 1'b1);
    set_pacing(12, 12);
    run_random(90);
    wait_drained();

    if (err_count == 0) begin
      $display("html_text_minifier_unit regression: pass");
    end else begin
      $display("html_text_minifier_unit regression: fail");
    end
    $finish;
  end

endmodule
